// ----- rtl/smou_pkg.sv -----
// Shared types and constants for the scalar unit modulo the curve order.
// Depends on nothing; used by the datapath and its port checker.
`default_nettype none
package smou_pkg;
	typedef logic [1:0] mode_t;

	localparam mode_t MODE_SUB   = 2'd0;
	localparam mode_t MODE_HALF  = 2'd1;
	localparam mode_t MODE_CHECK = 2'd2;
	localparam mode_t MODE_WIDE  = 2'd3;

	localparam int LIMB_W = 64;
	localparam int VAL_W  = 256;
	localparam int IN_W   = 640;
	localparam int OUT_W  = 264;

	// r = 2^254 + R0
	localparam logic [125:0] R0 = 126'h2ACF567A912B7F03DCF2AC65396152C7;
	localparam logic [127:0] R0X4 = {R0, 2'b00};
	localparam logic [255:0] R_ORD = {2'b01, 128'd0, R0};
	// (r + 1) / 2
	localparam logic [255:0] R_HALF =
		256'h2000000000000000_0000000000000000_1567AB3D4895BF81_EE7956329CB0A964;
endpackage
`default_nettype wire

// ----- rtl/scalar_mod_order_unit.sv -----
// Scalar unit modulo the curve order r: subtract, halve, range check, 384-bit reduce.
// Depends on smou_pkg.
//
// Input stream: s_axis_tdata carries a_0..a_5 then b_0..b_3 (64 bits each,
// lowest bits first), s_axis_tuser carries the 2-bit mode. Output stream:
// m_axis_tdata carries result_0..result_3 then is_reduced, zero padded.
// Each input beat gives exactly one output beat, in order.
// Throughput is one beat per cycle while the receiver does not stall: nine
// register stages (partial products, product row sums, product sum, wide
// subtract, fold, small multiply by r0, subtract, add back, final
// conditional subtract) all advance together.
// The 128x128 product of mode 3 is formed from sixteen 32x32 partials.
// When the receiver stalls, the whole pipe holds and s_axis_tready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears every stage valid bit; the output is idle after reset.
`default_nettype none
module scalar_mod_order_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_axis_tvalid,
	output logic                    s_axis_tready,
	// a_0, a_1, a_2, a_3, a_4, a_5, b_0, b_1, b_2, b_3
	input  wire  [smou_pkg::IN_W-1:0]  s_axis_tdata,
	// mode
	input  wire  [1:0]              s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  wire                     m_axis_tready,
	// result_0, result_1, result_2, result_3, is_reduced, 7 zero bits
	output logic [smou_pkg::OUT_W-1:0] m_axis_tdata
);
	import smou_pkg::*;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [8:0] v_q;

	// stage 1 inputs
	logic [VAL_W-1:0] in_a, in_b, half_v, val_in;
	logic [VAL_W:0]   diff_in;
	logic [127:0]     in_hi;
	mode_t            in_mode;
	logic [63:0]      pp_in [4][4];

	assign in_a    = s_axis_tdata[255:0];
	assign in_hi   = s_axis_tdata[383:256];
	assign in_b    = s_axis_tdata[639:384];
	assign in_mode = s_axis_tuser;
	assign diff_in = {1'b0, in_a} - {1'b0, in_b};
	assign half_v  = (in_a >> 1) + (in_a[0] ? R_HALF : '0);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pp_in[i][j] = 64'(in_hi[32*i +: 32]) * 64'(R0X4[32*j +: 32]);
			end
		end
	end

	always_comb begin
		case (in_mode)
			MODE_SUB:  val_in = diff_in[VAL_W-1:0];
			MODE_HALF: val_in = half_v;
			default:   val_in = in_a;
		endcase
	end

	mode_t            mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7, mode_s8;
	logic [VAL_W-1:0] val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7, val_s8;
	logic             bor_s1, bor_s4, bor_s7;
	logic [63:0]      pp_s1 [4][4];
	logic [1:0]       hi_s2, hi_s3, hi_s4, hi_s5;
	logic [159:0]     row_s2 [4];
	logic [VAL_W-1:0] p_s3;
	logic [129:0]     u_s6;

	// stage 2: fold 4r0 into a negative difference, row sums of the product
	logic [VAL_W:0]   fold2;
	logic [159:0]     row_c [4];
	assign fold2 = {1'b0, val_s1} + {129'd0, (bor_s1 ? R0X4 : 128'd0)};
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < 4; j++) begin
				row_c[i] = row_c[i] + (160'(pp_s1[i][j]) << (32*j));
			end
		end
	end

	// stage 3: product sum
	logic [VAL_W-1:0] p_c;
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 4; i++) begin
			p_c = p_c + (256'(row_s2[i]) << (32*i));
		end
	end

	// stage 4: low half minus product
	logic [VAL_W:0] sub4;
	assign sub4 = {1'b0, val_s3} - {1'b0, p_s3};

	// stage 5: add 4r, track bits above 2^256
	logic [VAL_W:0] add5;
	assign add5 = {1'b0, val_s4} + {129'd0, R0X4};

	// stage 6: multiple of r0 to remove
	logic [3:0] ah6;
	assign ah6 = {hi_s5, val_s5[255:254]};

	// stage 7/8/9
	logic [VAL_W:0] sub7, fin9;
	logic [VAL_W-1:0] add8;
	assign sub7 = {1'b0, val_s6} - {127'd0, u_s6};
	assign add8 = val_s7 + R_ORD;
	assign fin9 = {1'b0, val_s8} - {1'b0, R_ORD};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[7:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = v_q[8];

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_mode;
			val_s1  <= val_in;
			bor_s1  <= (in_mode == MODE_SUB) && diff_in[VAL_W];
			pp_s1   <= pp_in;

			mode_s2 <= mode_s1;
			val_s2  <= (mode_s1 == MODE_SUB) ? fold2[VAL_W-1:0] : val_s1;
			hi_s2   <= (mode_s1 == MODE_SUB) ? {1'b0, fold2[VAL_W]} : 2'd0;
			row_s2  <= row_c;

			mode_s3 <= mode_s2;
			val_s3  <= val_s2;
			hi_s3   <= hi_s2;
			p_s3    <= p_c;

			mode_s4 <= mode_s3;
			val_s4  <= (mode_s3 == MODE_WIDE) ? sub4[VAL_W-1:0] : val_s3;
			bor_s4  <= sub4[VAL_W];
			hi_s4   <= hi_s3;

			mode_s5 <= mode_s4;
			if (mode_s4 == MODE_WIDE) begin
				val_s5 <= add5[VAL_W-1:0];
				hi_s5  <= 2'd1 + {1'b0, add5[VAL_W]} - {1'b0, bor_s4};
			end else begin
				val_s5 <= val_s4;
				hi_s5  <= hi_s4;
			end

			mode_s6 <= mode_s5;
			// check mode skips the partial reduction
			if (mode_s5 == MODE_CHECK) begin
				val_s6 <= val_s5;
				u_s6   <= '0;
			end else begin
				val_s6 <= {2'b00, val_s5[253:0]};
				u_s6   <= 130'(R0) * 130'(ah6);
			end

			mode_s7 <= mode_s6;
			val_s7  <= sub7[VAL_W-1:0];
			bor_s7  <= sub7[VAL_W];

			mode_s8 <= mode_s7;
			val_s8  <= bor_s7 ? add8 : val_s7;

			if (mode_s8 == MODE_CHECK) begin
				m_axis_tdata <= {7'd0, fin9[VAL_W], 256'd0};
			end else begin
				m_axis_tdata <= {7'd0, 1'b0, (fin9[VAL_W] ? val_s8 : fin9[VAL_W-1:0])};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/smou_checker.sv -----
// Port-level checker for the scalar unit, bound to the top level.
// Depends on smou_pkg.
`default_nettype none
module smou_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_axis_tvalid,
	input wire                        s_axis_tready,
	input wire [smou_pkg::IN_W-1:0]   s_axis_tdata,
	input wire [1:0]                  s_axis_tuser,
	input wire                        m_axis_tvalid,
	input wire                        m_axis_tready,
	input wire [smou_pkg::OUT_W-1:0]  m_axis_tdata
);
	import smou_pkg::*;

	// a stalled output beat must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");

	// input side takes beats exactly when the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output slot");

	// flag beats carry a zero value, and padding stays zero
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[VAL_W] |-> m_axis_tdata[VAL_W-1:0] == '0)
		else $error("flag beat with nonzero value");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:VAL_W+1] == '0)
		else $error("padding bits set");

	// output idle right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid out of reset");
endmodule

bind scalar_mod_order_unit smou_checker u_smou_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_scalar_mod_order_unit.sv -----
// Testbench for scalar_mod_order_unit: directed table plus random operands,
// checked against known table results or an in-bench modular predictor.
// Depends on smou_pkg and the RTL of scalar_mod_order_unit.
`default_nettype none
module tb_scalar_mod_order_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import smou_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int N_RANDOM = 650;
	localparam logic [255:0] ALL1 = {256{1'b1}};

	typedef struct {
		mode_t        mode;
		logic [383:0] a;
		logic [255:0] b;
		logic         known;
		logic [255:0] res;
		logic         red;
	} op_row_t;

	typedef struct {
		logic [255:0] res;
		logic         red;
	} residue_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	residue_t pending_q[$];
	op_row_t  dir_rows[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit send_done = 1'b0;
	bit quiet = 1'b0;
	bit timed_out = 1'b0;

	scalar_mod_order_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// exact residue by wide integer arithmetic
	function automatic residue_t mod_order_result(mode_t mode, logic [383:0] a,
			logic [255:0] b);
		residue_t r;
		logic [384:0] w;
		r.res = '0;
		r.red = 1'b0;
		case (mode)
			MODE_SUB: begin
				w = {129'd0, a[255:0]} + ({129'd0, R_ORD} << 2) - {129'd0, b};
				if (a[255:0] >= b)
					w = {129'd0, a[255:0]} - {129'd0, b};
				r.res = 256'(w % {129'd0, R_ORD});
			end
			MODE_HALF: begin
				w = {129'd0, a[255:0]} % {129'd0, R_ORD};
				if (w[0])
					w = w + {129'd0, R_ORD};
				r.res = 256'(w >> 1);
			end
			MODE_CHECK:
				r.red = a[255:0] < R_ORD;
			default:
				r.res = 256'({1'b0, a} % {129'd0, R_ORD});
		endcase
		return r;
	endfunction

	function automatic logic [255:0] rand256();
		logic [255:0] v;
		for (int i = 0; i < 8; i++)
			v[i*32 +: 32] = $urandom;
		case ($urandom_range(0, 7))
			0: v = R_ORD - $urandom_range(0, 3);
			1: v = R_ORD + $urandom_range(0, 3);
			2: v = ALL1 - $urandom_range(0, 3);
			3: v = v >> $urandom_range(1, 255);
			default: ;
		endcase
		return v;
	endfunction

	function automatic op_row_t mk_row(mode_t m, logic [383:0] a, logic [255:0] b,
			logic known, logic [255:0] res, logic red);
		op_row_t row;
		row.mode = m;
		row.a = a;
		row.b = b;
		row.known = known;
		row.res = res;
		row.red = red;
		return row;
	endfunction

	task automatic send_beat(op_row_t row);
		residue_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= row.mode;
		s_axis_tdata <= {row.b, row.a};
		r = row.known ? residue_t'{row.res, row.red}
			: mod_order_result(row.mode, row.a, row.b);
		pending_q.push_back(r);
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic idle_gap(bit allow);
		if (allow && $urandom_range(0, 99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	initial begin
		op_row_t row;
		logic [383:0] wa;
		dir_rows.push_back(mk_row(MODE_SUB, '0, '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_SUB, 384'(R_ORD), '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_SUB, '0, 256'd1, 1'b1, R_ORD - 1, 1'b0));
		dir_rows.push_back(mk_row(MODE_SUB, 384'(ALL1), ALL1, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_SUB, '0, ALL1, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_SUB, {128'hFFFF, 256'(ALL1)}, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_HALF, '0, ALL1, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_HALF, 384'd1, '0, 1'b1, R_HALF, 1'b0));
		dir_rows.push_back(mk_row(MODE_HALF, 384'(R_ORD), '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_HALF, 384'(ALL1), '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_HALF, 384'(R_ORD - 1), '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_CHECK, '0, '0, 1'b1, '0, 1'b1));
		dir_rows.push_back(mk_row(MODE_CHECK, 384'(R_ORD - 1), ALL1, 1'b1, '0, 1'b1));
		dir_rows.push_back(mk_row(MODE_CHECK, 384'(R_ORD), '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_CHECK, ~384'd0, '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_WIDE, '0, ALL1, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_WIDE, 384'(R_ORD), '0, 1'b1, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_WIDE, ~384'd0, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_WIDE, {128'd1, 256'd0}, '0, 1'b0, '0, 1'b0));
		dir_rows.push_back(mk_row(MODE_WIDE, {128'hFFFF_FFFF, 256'(R_ORD)}, '0, 1'b0,
			'0, 1'b0));

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			idle_gap(1'b1);
			send_beat(dir_rows[i]);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			// long run without sender gaps in the middle
			idle_gap(n < 200 || n > 400);
			wa = {128'(rand256()), rand256()};
			if ($urandom_range(0, 3) == 0)
				wa[383:256] = ~wa[383:256];
			row = mk_row(mode_t'($urandom_range(0, 3)), wa, rand256(), 1'b0, '0, 1'b0);
			send_beat(row);
		end
		s_axis_tvalid <= 1'b0;
		send_done = 1'b1;
	end

	// receiver: random stalls, one long hold-off, quiet stretch
	initial begin
		wait (arst_n);
		repeat (60)
			@(posedge clk);
		m_axis_tready <= 1'b0;
		repeat (80)
			@(posedge clk);
		forever begin
			@(posedge clk);
			quiet = pending_q.size() > 0 && $urandom_range(0, 999) < 2 ? ~quiet : quiet;
			m_axis_tready <= quiet || $urandom_range(0, 99) >= 8;
		end
	end

	always @(posedge clk) begin
		residue_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %h", m_axis_tdata);
			end else begin
				exp_r = pending_q.pop_front();
				if (m_axis_tdata[255:0] !== exp_r.res || m_axis_tdata[256] !== exp_r.red
						|| m_axis_tdata[263:257] !== 7'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp res %h red %b, got res %h red %b pad %h",
							exp_r.res, exp_r.red, m_axis_tdata[255:0],
							m_axis_tdata[256], m_axis_tdata[263:257]);
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (!(send_done && pending_q.size() == 0) && idle_cycles < WATCHDOG)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG)
			timed_out = 1'b1;
		else
			repeat (20)
				@(posedge clk);
		if (timed_out || mismatches != 0)
			$display("CHECK FAILED");
		else
			$display("CHECK OK");
		$finish;
	end
endmodule
`default_nettype wire

// ----- scalar_mod_order_unit.f -----
rtl/smou_pkg.sv
rtl/scalar_mod_order_unit.sv
rtl/smou_checker.sv
tb/sv/tb_scalar_mod_order_unit.sv
